### sv/pobc_pkg.sv
package pobc_pkg;

  localparam int PERIOD_W  = 8;
  localparam int REPEAT_W  = 7;
  localparam int DIVIDER_W = 16;
  localparam int SWEEP_W   = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD  = 2'd0,
    CFG_REPEAT  = 2'd1,
    CFG_DIVIDER = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_idx_t;

  localparam logic [PERIOD_W-1:0]  RST_PERIOD  = 8'd24;
  localparam logic [REPEAT_W-1:0]  RST_REPEAT  = 7'd10;
  localparam logic [DIVIDER_W-1:0] RST_DIVIDER = 16'd800;
  localparam logic [PERIOD_W-1:0]  RST_OFFSET  = 8'd23;

  typedef struct packed {
    logic [DIVIDER_W-1:0] prescale;
    logic [PERIOD_W-1:0]  offset;
    logic                 sweep_up;
    logic [SWEEP_W-1:0]   sweep_ticks;
    logic                 auto_active;
    logic                 waiting;
    logic                 last_dn;
    logic                 last_up;
    logic [REPEAT_W-1:0]  held_dn;
    logic [REPEAT_W-1:0]  held_up;
  } state_t;

endpackage

### sv/pobc_in_if.sv
interface pobc_in_if;
  logic valid;
  logic ready;
  logic down_pressed;
  logic up_pressed;

  modport source (output valid, output down_pressed, output up_pressed, input ready);
  modport sink   (input valid, input down_pressed, input up_pressed, output ready);
endinterface

### sv/pobc_out_if.sv
interface pobc_out_if;
  logic                          valid;
  logic                          ready;
  logic [pobc_pkg::PERIOD_W-1:0] phase_offset;
  logic                          offset_written;
  logic                          sweeping;

  modport source (output valid, output phase_offset, output offset_written,
                  output sweeping, input ready);
  modport sink   (input valid, input phase_offset, input offset_written,
                  input sweeping, output ready);
endinterface

### sv/pobc_cfg_if.sv
interface pobc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pobc_pkg::CFG_IDX_W-1:0] index;
  logic [pobc_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/phase_offset_button_controller_top.sv
// A result is in the output register in the cycle after its input beat.
// Throughput: one item per cycle while out_ch.ready holds; the output register frees when its beat is
// taken, so a new input beat is accepted in the same cycle the old result leaves.
// Reset (rst_n low, synchronous): period 24, repeat delay 10, divider 800,
// offset 23, sweep direction up, all counters and mode flags cleared, output empty.
module phase_offset_button_controller_top (
  input  logic              clk,
  input  logic              rst_n,
  pobc_in_if.sink           in_ch,
  pobc_out_if.source        out_ch,
  pobc_cfg_if.sink          cfg_ch
);

  logic [pobc_pkg::PERIOD_W-1:0]  period_r;
  logic [pobc_pkg::REPEAT_W-1:0]  repeat_r;
  logic [pobc_pkg::DIVIDER_W-1:0] divider_r;

  pobc_pkg::state_t st_r, st_nxt;

  logic                          out_valid_r;
  logic [pobc_pkg::PERIOD_W-1:0] out_offset_r;
  logic                          out_written_r;
  logic                          out_sweeping_r;

  logic in_fire;
  logic tick;
  logic wrote;
  logic [pobc_pkg::DIVIDER_W:0] pre_inc;

  function automatic logic [pobc_pkg::REPEAT_W-1:0] update_held(
    input logic                          pressed,
    input logic [pobc_pkg::REPEAT_W-1:0] held,
    input logic [pobc_pkg::REPEAT_W-1:0] delay
  );
    logic [pobc_pkg::REPEAT_W-1:0] h;
    h = held;
    if (!pressed) begin
      h = '0;
    end else if (h < delay) begin
      h = h + 1'b1;
    end
    return h;
  endfunction

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign pre_inc = {1'b0, st_r.prescale} + 1'b1;
  assign tick    = pre_inc >= {1'b0, divider_r};

  always_comb begin
    logic                          dn, up, go;
    logic [pobc_pkg::PERIOD_W:0]   v;
    logic [pobc_pkg::PERIOD_W-1:0] wrap;
    logic [pobc_pkg::SWEEP_W-1:0]  cnt;
    dn     = in_ch.down_pressed;
    up     = in_ch.up_pressed;
    go     = 1'b0;
    v      = '0;
    cnt    = '0;
    wrap   = period_r - 1'b1;
    st_nxt = st_r;
    wrote  = 1'b0;
    if (!tick) begin
      st_nxt.prescale = pre_inc[pobc_pkg::DIVIDER_W-1:0];
    end else begin
      st_nxt.prescale = '0;
      if (st_r.auto_active) begin
        if (dn || up) begin
          st_nxt.auto_active = 1'b0;
        end
        if (st_r.sweep_up) begin
          v = {1'b0, st_r.offset} + 1'b1;
        end else if (st_r.offset == '0) begin
          v = {1'b0, wrap};
        end else begin
          v = {1'b0, st_r.offset - 1'b1};
        end
        if (v >= {1'b0, period_r}) begin
          v = '0;
        end
        st_nxt.offset = v[pobc_pkg::PERIOD_W-1:0];
        cnt = st_r.sweep_ticks - 1'b1;
        if (cnt == '0) begin
          st_nxt.sweep_up    = !st_r.sweep_up;
          st_nxt.sweep_ticks = {period_r, 1'b0};
        end else begin
          st_nxt.sweep_ticks = cnt;
        end
        wrote = 1'b1;
      end else begin
        go = 1'b1;
        if (st_r.waiting) begin
          if (dn || up) begin
            go = 1'b0;
          end else begin
            // both released: sweep starts at the half count
            st_nxt.waiting     = 1'b0;
            st_nxt.auto_active = 1'b1;
            st_nxt.sweep_up    = 1'b1;
            st_nxt.sweep_ticks = {1'b0, period_r};
          end
        end else if (dn && up) begin
          st_nxt.waiting = 1'b1;
          go = 1'b0;
        end
        if (go) begin
          st_nxt.held_dn = update_held(dn, st_r.held_dn, repeat_r);
          st_nxt.held_up = update_held(up, st_r.held_up, repeat_r);
          if ((!dn && st_r.last_dn) || st_nxt.held_dn == repeat_r) begin
            st_nxt.offset = (st_r.offset == '0) ? wrap : st_r.offset - 1'b1;
            wrote = 1'b1;
          end
          if ((!up && st_r.last_up) || st_nxt.held_up == repeat_r) begin
            v = {1'b0, st_nxt.offset} + 1'b1;
            if (v >= {1'b0, period_r}) begin
              v = '0;
            end
            st_nxt.offset = v[pobc_pkg::PERIOD_W-1:0];
            wrote = 1'b1;
          end
          st_nxt.last_dn = dn;
          st_nxt.last_up = up;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= pobc_pkg::RST_PERIOD;
      repeat_r  <= pobc_pkg::RST_REPEAT;
      divider_r <= pobc_pkg::RST_DIVIDER;
    end else if (cfg_ch.valid) begin
      case (pobc_pkg::cfg_idx_t'(cfg_ch.index))
        pobc_pkg::CFG_PERIOD:  period_r  <= cfg_ch.data[pobc_pkg::PERIOD_W-1:0];
        pobc_pkg::CFG_REPEAT:  repeat_r  <= cfg_ch.data[pobc_pkg::REPEAT_W-1:0];
        pobc_pkg::CFG_DIVIDER: divider_r <= cfg_ch.data[pobc_pkg::DIVIDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.prescale    <= '0;
      st_r.offset      <= pobc_pkg::RST_OFFSET;
      st_r.sweep_up    <= 1'b1;
      st_r.sweep_ticks <= '0;
      st_r.auto_active <= 1'b0;
      st_r.waiting     <= 1'b0;
      st_r.last_dn     <= 1'b0;
      st_r.last_up     <= 1'b0;
      st_r.held_dn     <= '0;
      st_r.held_up     <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_offset_r   <= st_nxt.offset;
      out_written_r  <= wrote;
      out_sweeping_r <= st_nxt.auto_active;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.phase_offset   = out_offset_r;
  assign out_ch.offset_written = out_written_r;
  assign out_ch.sweeping       = out_sweeping_r;

  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.waiting && st_r.auto_active))
    else $error("waiting for release while sweeping");

  a_idle_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !tick |=> $stable(st_r.offset) && !out_written_r)
    else $error("offset touched on a non-tick beat");

  a_sweep_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && st_r.auto_active |=> $stable(st_r.held_dn) && $stable(st_r.held_up))
    else $error("held counters moved during sweep");

  a_sweep_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && tick && st_r.auto_active |=> out_valid_r && out_written_r)
    else $error("sweep tick did not write the offset");

endmodule
